// ===== hdl/decimal_field_formatter_assert.svh =====
// Assertion macros for the checker file of the decimal field formatter.
`ifndef DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define DECIMAL_FIELD_FORMATTER_ASSERT_SVH

// Property checked at every rising clock edge while out of reset.
`define DFMT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dfmt assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DFMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dfmt assertion failed");

`endif

// ===== hdl/dfmt_pkg.sv =====
// Types and constants shared by the decimal field formatter.
`default_nettype none
package dfmt_pkg;

  localparam int DigitSlots = 10;

  localparam logic [5:0] ChSpace = 6'd32;
  localparam logic [5:0] ChMinus = 6'd45;
  localparam logic [5:0] ChZero  = 6'd48;
  localparam logic [5:0] ChNine  = 6'd57;

  localparam logic [7:0] StepShort = 8'd6;
  localparam logic [7:0] StepTall  = 8'd8;

  // floor(x / 10) == (x * Recip10) >> RecipShift for every 32-bit x
  localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
  localparam int          RecipShift = 35;

  typedef enum logic [1:0] {
    FeIdle,
    FeConv,
    FeDone
  } fe_state_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] value;
    logic [3:0]  field_len;
    logic [7:0]  start_col;
    logic [2:0]  page_row;
    logic        tall_font;
  } dfmt_req_t;

  typedef struct packed {
    logic [5:0] char_code;
    logic [7:0] cell_col;
    logic [2:0] cell_page;
    logic       last;
  } dfmt_cell_t;

  typedef struct packed {
    logic                        sign_cell;
    logic                        neg;
    logic [3:0]                  len;
    logic [7:0]                  col;
    logic [2:0]                  page;
    logic                        tall;
    logic [DigitSlots-1:0][3:0]  digits;
  } dfmt_job_t;

endpackage
`default_nettype wire

// ===== hdl/dfmt_if.sv =====
// Valid/ready channel interfaces for requests and character cells.
`default_nettype none
interface dfmt_req_if import dfmt_pkg::*; ();
  logic      valid;
  logic      ready;
  dfmt_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dfmt_cell_if import dfmt_pkg::*; ();
  logic       valid;
  logic       ready;
  dfmt_cell_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/dfmt_fifo.sv =====
// Two-entry queue between the digit front end and the cell emitter.
`default_nettype none
module dfmt_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [Width-1:0] in_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic [Width-1:0] out_data_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule
`default_nettype wire

// ===== hdl/dfmt_front.sv =====
// Front end: takes requests, classifies sign and length, extracts decimal digits.
`default_nettype none
module dfmt_front import dfmt_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfmt_req_if.sink   req_i,
  output dfmt_job_t  job_o,
  output logic       job_valid_o,
  input  logic       job_ready_i
);

  localparam int CntW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_DIGITS - 1);

  fe_state_e                   state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [31:0]                 mag_q, mag_d;
  logic [MAX_DIGITS-1:0][3:0]  digs_q, digs_d;
  logic                        sign_q, neg_q, tall_q;
  logic [3:0]                  len_q;
  logic [7:0]                  col_q;
  logic [2:0]                  page_q;

  logic        accept;
  logic        req_neg;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_full;

  assign req_neg  = req_i.payload.req_type && req_i.payload.value[31];
  assign prod     = 64'(mag_q) * 64'(Recip10);
  assign quot     = 32'(prod >> RecipShift);
  assign rem_full = mag_q - ((quot << 3) + (quot << 1));

  assign req_i.ready = (state_q == FeIdle) || ((state_q == FeDone) && job_ready_i);
  assign accept      = req_i.valid && req_i.ready;
  assign job_valid_o = (state_q == FeDone);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    digs_d  = digs_q;
    if (accept) begin
      mag_d = req_neg ? (~req_i.payload.value + 32'd1) : req_i.payload.value;
      cnt_d = '0;
    end
    case (state_q)
      FeIdle: begin
        if (accept) state_d = FeConv;
      end
      FeConv: begin
        digs_d                 = digs_q >> 4;
        digs_d[MAX_DIGITS-1]   = rem_full[3:0];
        mag_d                  = quot;
        cnt_d                  = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = FeDone;
      end
      FeDone: begin
        if (job_ready_i) state_d = accept ? FeConv : FeIdle;
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    digs_q <= digs_d;
    if (accept) begin
      sign_q <= req_i.payload.req_type;
      neg_q  <= req_neg;
      len_q  <= (req_i.payload.field_len > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS)
                                                            : req_i.payload.field_len;
      col_q  <= req_i.payload.start_col;
      page_q <= req_i.payload.page_row;
      tall_q <= req_i.payload.tall_font;
    end
  end

  always_comb begin
    job_o           = '0;
    job_o.sign_cell = sign_q;
    job_o.neg       = neg_q;
    job_o.len       = len_q;
    job_o.col       = col_q;
    job_o.page      = page_q;
    job_o.tall      = tall_q;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      job_o.digits[i] = digs_q[i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dfmt_back.sv =====
// Back end: walks one job and emits its character cells, most significant first.
`default_nettype none
module dfmt_back import dfmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dfmt_job_t  job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  dfmt_cell_if.source cell_o
);

  logic                       busy_q, sign_q, ov_q;
  logic                       neg_q, len_zero_q, showing_q, tall_q;
  logic [3:0]                 di_q;
  logic [7:0]                 col_q;
  logic [2:0]                 page_q;
  logic [DigitSlots-1:0][3:0] digs_q;
  dfmt_cell_t                 cell_q;

  logic       adv, emit, pop, done;
  logic [3:0] dig;
  logic       fin_digit, blank, cell_last;
  logic [5:0] ch;
  logic [7:0] step;

  assign adv       = !ov_q || cell_o.ready;
  assign emit      = busy_q && adv;
  assign dig       = digs_q[di_q];
  assign fin_digit = (di_q == 4'd0);
  assign blank     = !showing_q && !fin_digit && (dig == 4'd0);
  assign step      = tall_q ? StepTall : StepShort;

  always_comb begin
    if (sign_q) begin
      ch        = neg_q ? ChMinus : ChSpace;
      cell_last = len_zero_q;
    end else begin
      ch        = blank ? ChSpace : (ChZero + {2'b00, dig});
      cell_last = fin_digit;
    end
  end

  assign done        = emit && cell_last;
  assign job_ready_o = !busy_q || done;
  assign pop         = job_valid_i && job_ready_o;

  assign cell_o.valid   = ov_q;
  assign cell_o.payload = cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (emit) begin
        ov_q <= 1'b1;
      end else if (adv) begin
        ov_q <= 1'b0;
      end
      if (pop) begin
        busy_q <= job_i.sign_cell || (job_i.len != 4'd0);
        sign_q <= job_i.sign_cell;
      end else if (emit) begin
        if (cell_last) busy_q <= 1'b0;
        sign_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cell_q.char_code <= ch;
      cell_q.cell_col  <= col_q;
      cell_q.cell_page <= page_q;
      cell_q.last      <= cell_last;
    end
    if (pop) begin
      neg_q      <= job_i.neg;
      len_zero_q <= (job_i.len == 4'd0);
      di_q       <= job_i.len - 4'd1;
      showing_q  <= 1'b0;
      col_q      <= job_i.col;
      page_q     <= job_i.page;
      tall_q     <= job_i.tall;
      digs_q     <= job_i.digits;
    end else if (emit) begin
      col_q <= col_q + step;
      if (!sign_q) begin
        di_q      <= di_q - 4'd1;
        showing_q <= showing_q || !blank;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/decimal_field_formatter.sv =====
// Top level of the decimal field formatter: number to blanked decimal character cells.
//
//   channel  | dir | payload                                              | handshake
//   req_i    | in  | req_type value field_len start_col page_row tall_font | valid/ready
//   cell_o   | out | char_code cell_col cell_page last                    | valid/ready
//
// Front end extracts the digits of a request, one reciprocal multiply by 1/10
// per cycle, and then holds the job until the queue takes it.
// Back end: one cell per cycle unless stalled; capped field length plus one if signed.
// The front end converts a new request while the back end still emits older cells.
// Async active-low reset clears control only; no clearing pass is needed.
// Either side may stall; a two-entry queue parts front and back.
`default_nettype none
module decimal_field_formatter import dfmt_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dfmt_req_if.sink     req_i,
  dfmt_cell_if.source  cell_o
);

  dfmt_job_t front_job;
  dfmt_job_t fifo_job;
  logic      front_valid, front_ready;
  logic      fifo_valid, fifo_ready;

  dfmt_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  dfmt_fifo #(
    .Width ($bits(dfmt_job_t))
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (front_job),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_data_o  (fifo_job),
    .out_valid_o (fifo_valid),
    .out_ready_i (fifo_ready)
  );

  dfmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (fifo_job),
    .job_valid_i (fifo_valid),
    .job_ready_o (fifo_ready),
    .cell_o      (cell_o)
  );

endmodule
`default_nettype wire

// ===== hdl/dfmt_checker.sv =====
// Port-level checks on the cell output of the decimal field formatter, with bind.
`default_nettype none
`include "decimal_field_formatter_assert.svh"
module dfmt_checker import dfmt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cell_valid_i,
  input logic       cell_ready_i,
  input dfmt_cell_t cell_i
);

  `DFMT_ASSERT_NEXT(a_cell_hold, clk_i, rst_ni, cell_valid_i && !cell_ready_i, cell_valid_i && $stable(cell_i))

  `DFMT_ASSERT(a_char_legal, clk_i, rst_ni, cell_valid_i |-> (cell_i.char_code == ChSpace || cell_i.char_code == ChMinus || (cell_i.char_code >= ChZero && cell_i.char_code <= ChNine)))

  `DFMT_ASSERT(a_col_step, clk_i, rst_ni, (cell_valid_i && cell_ready_i && !cell_i.last) ##1 cell_valid_i |-> ((cell_i.cell_col == ($past(cell_i.cell_col) + StepShort) || cell_i.cell_col == ($past(cell_i.cell_col) + StepTall)) && cell_i.cell_page == $past(cell_i.cell_page)))

endmodule

bind decimal_field_formatter dfmt_checker u_dfmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cell_valid_i (cell_o.valid),
  .cell_ready_i (cell_o.ready),
  .cell_i       (cell_o.payload)
);
`default_nettype wire

// ===== bench/decimal_field_formatter_test.sv =====
// Self-checking testbench for decimal_field_formatter: directed and random requests checked cell by cell.
`default_nettype none
module decimal_field_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dfmt_pkg::*;

  localparam int MaxDigits = 10;
  localparam int RandomReqs = 290;
  localparam int HoldCycles = 400;
  localparam int HoldAtReq = 60;
  localparam int CalmFrom = 150;
  localparam int CalmTo = 200;
  localparam int DrainCycles = 50;
  localparam logic ReqUnsigned = 1'b0;
  localparam logic ReqSigned = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;

  dfmt_req_if req_ch ();
  dfmt_cell_if cell_ch ();

  decimal_field_formatter #(.MAX_DIGITS(MaxDigits)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .cell_o(cell_ch)
  );

  dfmt_req_t  reqs_to_send[$];
  dfmt_cell_t cells_due[$];

  int errors = 0;
  int n_reqs = 0;
  int n_signed = 0;
  int n_empty = 0;
  int n_sat = 0;
  int n_cells = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH cell %0d %s: got %0d, expected %0d", $realtime, n_cells, what,
             got, want);
    errors++;
  endtask

  // Expected cells of one request, appended in emission order.
  function automatic void expand_request(input dfmt_req_t r);
    logic [31:0] mag;
    logic [3:0]  digit [0:9];
    logic [7:0]  col;
    logic [7:0]  step;
    logic [3:0]  d;
    int          n;
    bit          showing;
    bit          final_cell;
    dfmt_cell_t  c;
    mag = r.value;
    n = (r.field_len > MaxDigits) ? MaxDigits : int'(r.field_len);
    step = r.tall_font ? StepTall : StepShort;
    col = r.start_col;
    showing = 1'b0;
    if (r.req_type == ReqSigned) begin
      if (r.value[31]) mag = ~r.value + 32'd1;
      c.char_code = r.value[31] ? ChMinus : ChSpace;
      c.cell_col = col;
      c.cell_page = r.page_row;
      c.last = (n == 0);
      cells_due.push_back(c);
      col = col + step;
    end
    for (int i = 0; i < 10; i++) begin
      digit[i] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
    end
    for (int t = 0; t < n; t++) begin
      d = digit[n - 1 - t];
      final_cell = (t == n - 1);
      if (!showing && !final_cell && d == 4'd0) begin
        c.char_code = ChSpace;
      end else begin
        showing = 1'b1;
        c.char_code = ChZero + 6'(d);
      end
      c.cell_col = col;
      c.cell_page = r.page_row;
      c.last = final_cell;
      cells_due.push_back(c);
      col = col + step;
    end
  endfunction

  function automatic dfmt_req_t make_req(input logic kind, input logic [31:0] value,
                                         input logic [3:0] len, input logic [7:0] col,
                                         input logic [2:0] page, input logic tall);
    dfmt_req_t r;
    r.req_type = kind;
    r.value = value;
    r.field_len = len;
    r.start_col = col;
    r.page_row = page;
    r.tall_font = tall;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = $urandom_range(1, 9) * (32'd10 ** $urandom_range(0, 9));
      3: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000 + $urandom_range(0, 3);
          1: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
          2: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
          default: v = $urandom_range(0, 3);
        endcase
      end
      4: v = $urandom_range(0, 99_999_999);
      default: v = -$urandom_range(0, 99_999);
    endcase
    return v;
  endfunction

  function automatic bit calm_phase();
    return n_reqs >= CalmFrom && n_reqs < CalmTo;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin : drive
    bit took;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      took = req_ch.valid && req_ch.ready;
      if (took) begin
        expand_request(req_ch.payload);
        n_reqs <= n_reqs + 1;
        if (req_ch.payload.req_type == ReqSigned) n_signed <= n_signed + 1;
        if (req_ch.payload.field_len == 4'd0) n_empty <= n_empty + 1;
        if (req_ch.payload.field_len > MaxDigits) n_sat <= n_sat + 1;
      end
      if (!req_ch.valid || took) begin
        if (reqs_to_send.size() != 0 && (calm_phase() || $urandom_range(99) >= 14)) begin
          req_ch.payload <= reqs_to_send.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while requests keep coming.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_used && n_reqs >= HoldAtReq) begin
        hold_used <= 1'b1;
        hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Cell monitor and checker.
  always @(posedge clk_i) begin : watch
    dfmt_cell_t got;
    dfmt_cell_t want;
    if (!rst_ni) begin
      cell_ch.ready <= 1'b0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) begin
        got = cell_ch.payload;
        if (cells_due.size() == 0) begin
          report_mismatch("unexpected cell, char_code", int'(got.char_code), -1);
        end else begin
          want = cells_due.pop_front();
          if (got.char_code !== want.char_code)
            report_mismatch("char_code", int'(got.char_code), int'(want.char_code));
          if (got.cell_col !== want.cell_col)
            report_mismatch("cell_col", int'(got.cell_col), int'(want.cell_col));
          if (got.cell_page !== want.cell_page)
            report_mismatch("cell_page", int'(got.cell_page), int'(want.cell_page));
          if (got.last !== want.last)
            report_mismatch("last", int'(got.last), int'(want.last));
        end
        n_cells <= n_cells + 1;
      end
      cell_ch.ready <= (hold_left == 0) && (calm_phase() || $urandom_range(99) >= 14);
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    dfmt_req_t r;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cell_ch.ready = 1'b0;

    // directed: extremes, zero length, saturation, wrap, blanking
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd0, 4'd10, 8'd0, 3'd0, 1'b0));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'hFFFF_FFFF, 4'd10, 8'd255, 3'd7, 1'b1));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd12345, 4'd0, 8'd10, 3'd1, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, 32'd12345, 4'd0, 8'd20, 3'd2, 1'b1));
    reqs_to_send.push_back(make_req(ReqSigned, 32'hFFFF_FFF0, 4'd0, 8'd30, 3'd3, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, 32'h8000_0000, 4'd10, 8'd0, 3'd4, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, 32'hFFFF_FFFF, 4'd10, 8'd200, 3'd5, 1'b1));
    reqs_to_send.push_back(make_req(ReqSigned, 32'h7FFF_FFFF, 4'd10, 8'd128, 3'd6, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, 32'd0, 4'd1, 8'd5, 3'd0, 1'b1));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd0, 4'd1, 8'd250, 3'd7, 1'b0));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd987654321, 4'd15, 8'd240, 3'd1, 1'b1));
    reqs_to_send.push_back(make_req(ReqSigned, 32'h8000_0000, 4'd15, 8'd250, 3'd2, 1'b1));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd4000000000, 4'd11, 8'd3, 3'd3, 1'b0));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd1234, 4'd2, 8'd100, 3'd4, 1'b0));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd1000, 4'd5, 8'd60, 3'd5, 1'b1));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd1000, 4'd3, 8'd60, 3'd6, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, -32'd7, 4'd4, 8'd252, 3'd7, 1'b0));
    reqs_to_send.push_back(make_req(ReqSigned, 32'd7, 4'd4, 8'd252, 3'd0, 1'b1));
    reqs_to_send.push_back(make_req(ReqUnsigned, 32'd100000, 4'd9, 8'd0, 3'd1, 1'b1));
    reqs_to_send.push_back(make_req(ReqSigned, -32'd100000, 4'd9, 8'd255, 3'd2, 1'b0));

    for (int i = 0; i < RandomReqs; i++) begin
      r.req_type = 1'($urandom_range(1));
      r.value = pick_value();
      r.field_len = ($urandom_range(9) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, MaxDigits));
      r.start_col = 8'($urandom_range(255));
      r.page_row = 3'($urandom_range(7));
      r.tall_font = 1'($urandom_range(1));
      reqs_to_send.push_back(r);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_to_send.size() != 0 || req_ch.valid || cells_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d requests (%0d signed, %0d zero-length, %0d oversized length)",
             n_reqs, n_signed, n_empty, n_sat);
    $display("Checked %0d character cells, including a %0d-cycle output stall",
             n_cells, HoldCycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
